// File: src/sha1_pkg.sv
// sha1_pkg: shared types, constants and round functions of the SHA-1 hasher.
// Used by sha1_sched, sha1_core, sha1_message_hasher and the bench tb; depends on nothing.
package sha1_pkg;

	localparam int unsigned NUM_H = 5;

	localparam logic [5:0] BLOCK_LAST   = 6'd63;
	localparam logic [5:0] LEN_POS      = 6'd56;
	localparam logic [7:0] PAD_MARK     = 8'h80;
	localparam logic [7:0] PAD_ZERO     = 8'h00;
	localparam logic [6:0] ROUND_LAST   = 7'd79;
	localparam logic [6:0] EARLY_ROUNDS = 7'd16;
	localparam logic [6:0] GROUP1_START = 7'd20;
	localparam logic [6:0] GROUP2_START = 7'd40;
	localparam logic [6:0] GROUP3_START = 7'd60;
	localparam logic [2:0] LAST_IDX     = 3'd4;

	typedef logic [NUM_H-1:0][31:0] hwords_t;

	// h0 sits at index 0
	localparam hwords_t H_INIT = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
		32'hefcdab89, 32'h67452301};

	typedef enum logic [1:0] {
		GRP_CH  = 2'd0,
		GRP_P1  = 2'd1,
		GRP_MAJ = 2'd2,
		GRP_P2  = 2'd3
	} round_grp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef struct packed {
		logic       shift_byte;
		logic [7:0] byte_val;
		logic       round_en;
		logic       early;
	} sched_ctrl_t;

	typedef struct packed {
		logic       load;
		logic       round_en;
		round_grp_t grp;
		logic       add;
		logic       init;
	} core_ctrl_t;

	function automatic logic [31:0] round_k(input round_grp_t g);
		logic [31:0] k;
		unique case (g)
			GRP_CH:  k = 32'h5A827999;
			GRP_P1:  k = 32'h6ED9EBA1;
			GRP_MAJ: k = 32'h8F1BBCDC;
			GRP_P2:  k = 32'hCA62C1D6;
			default: k = 32'h5A827999;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] round_f(input round_grp_t g, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z);
		logic [31:0] f;
		unique case (g)
			GRP_CH:  f = (x & y) | (~x & z);
			GRP_MAJ: f = (x & y) | (x & z) | (y & z);
			default: f = x ^ y ^ z;
		endcase
		return f;
	endfunction

endpackage

// File: src/sha1_sched.sv
// sha1_sched: 16-word window that gathers message bytes and rolls the schedule.
// Depends on sha1_pkg.
module sha1_sched (
	input  logic                    clk,
	input  sha1_pkg::sched_ctrl_t   ctrl,
	output logic [31:0]             w_t
);

	logic [31:0] win_q [16];
	logic [31:0] mixed;
	logic [31:0] w_new;

	// slot 0 holds the oldest word, slot 15 the newest
	assign mixed = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign w_new = {mixed[30:0], mixed[31]};
	assign w_t   = ctrl.early ? win_q[0] : w_new;

	always_ff @(posedge clk) begin
		if (ctrl.shift_byte) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], ctrl.byte_val};
		end else if (ctrl.round_en) begin
			// early rounds rotate the block back into place
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_t;
		end
	end

endmodule

// File: src/sha1_core.sv
// sha1_core: one shared SHA-1 round unit, working registers a..e and chaining words.
// Depends on sha1_pkg.
module sha1_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha1_pkg::core_ctrl_t   ctrl,
	input  logic [31:0]            w_t,
	output sha1_pkg::hwords_t      h
);

	sha1_pkg::hwords_t h_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] t_sum;

	assign t_sum = {a_q[26:0], a_q[31:27]} + sha1_pkg::round_f(ctrl.grp, b_q, c_q, d_q)
		+ e_q + w_t + sha1_pkg::round_k(ctrl.grp);
	assign h = h_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (ctrl.round_en) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= sha1_pkg::H_INIT;
		end else if (ctrl.init) begin
			h_q <= sha1_pkg::H_INIT;
		end else if (ctrl.add) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

endmodule

// File: src/sha1_message_hasher.sv
// sha1_message_hasher: SHA-1 over a byte stream; top level with sequencer and digest buffer.
// Depends on sha1_pkg, sha1_sched and sha1_core.
// A message arrives one byte per input beat; a beat with end_of_message set closes it,
// and may carry no byte so that an empty message works. Every 64th byte starts a
// compression on the single shared round unit: 80 rounds, then a fold of a..e into the
// chaining words, during all of which the input is not ready. On end of message the
// block pads one byte per cycle up to the end of the block (0x80, zeros, 64-bit
// big-endian bit length), which costs one or two compressions, then hands the digest
// to the output buffer. The five digest words h0..h4 then leave as five output beats,
// last_word marking h4. The output buffer drains on its own, so the next message may
// start while it is still being read; a following digest waits until the buffer is
// empty. On long messages the sustained byte rate is set by the one-round-per-cycle
// compression loop.
module sha1_message_hasher (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sha1_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sha1_pkg::out_item_t  out_data
);

	sha1_pkg::state_t      state_q, state_d;
	sha1_pkg::sched_ctrl_t sc;
	sha1_pkg::core_ctrl_t  cc;
	sha1_pkg::hwords_t     h;
	sha1_pkg::hwords_t     dig_q;
	sha1_pkg::round_grp_t  grp;

	logic [5:0]  fill_q;
	logic [60:0] byte_cnt_q;
	logic [6:0]  rnd_q;
	logic        pad_q, mark_q, extra_q, final_q;
	logic        out_valid_q;
	logic [2:0]  idx_q;

	logic [31:0] w_t;
	logic [63:0] len_bits;
	logic [7:0]  len_byte;
	logic        in_fire, out_fire;
	logic        fill_adv, cnt_adv, pad_set, mark_set, extra_set, extra_clr, final_set;
	logic        clear_msg, load_out;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (state_q == sha1_pkg::ST_IDLE);

	// length field: big-endian, byte k of the tail sits at fill 56 + k
	assign len_bits = {byte_cnt_q, 3'b000};
	assign len_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];

	always_comb begin
		if (rnd_q < sha1_pkg::GROUP1_START) begin
			grp = sha1_pkg::GRP_CH;
		end else if (rnd_q < sha1_pkg::GROUP2_START) begin
			grp = sha1_pkg::GRP_P1;
		end else if (rnd_q < sha1_pkg::GROUP3_START) begin
			grp = sha1_pkg::GRP_MAJ;
		end else begin
			grp = sha1_pkg::GRP_P2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: byte intake, padding, round loop, chaining add, digest hand-off.
	always_comb begin
		state_d     = state_q;
		sc          = '0;
		cc          = '0;
		cc.grp      = grp;
		sc.early    = (rnd_q < sha1_pkg::EARLY_ROUNDS);
		fill_adv    = 1'b0;
		cnt_adv     = 1'b0;
		pad_set     = 1'b0;
		mark_set    = 1'b0;
		extra_set   = 1'b0;
		extra_clr   = 1'b0;
		final_set   = 1'b0;
		clear_msg   = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (in_fire) begin
					pad_set = in_data.end_of_message;
					if (in_data.byte_present) begin
						sc.shift_byte = 1'b1;
						sc.byte_val   = in_data.data_byte;
						fill_adv      = 1'b1;
						cnt_adv       = 1'b1;
						if (fill_q == sha1_pkg::BLOCK_LAST) begin
							cc.load = 1'b1;
							state_d = sha1_pkg::ST_COMP;
						end else if (in_data.end_of_message) begin
							state_d = sha1_pkg::ST_PAD;
						end
					end else if (in_data.end_of_message) begin
						state_d = sha1_pkg::ST_PAD;
					end
				end
			end
			sha1_pkg::ST_PAD: begin
				sc.shift_byte = 1'b1;
				fill_adv      = 1'b1;
				if (!mark_q) begin
					sc.byte_val = sha1_pkg::PAD_MARK;
					mark_set    = 1'b1;
					// mark lands inside the length field but short of the block end
					extra_set   = (fill_q >= sha1_pkg::LEN_POS)
						&& (fill_q != sha1_pkg::BLOCK_LAST);
				end else if ((fill_q < sha1_pkg::LEN_POS) || extra_q) begin
					sc.byte_val = sha1_pkg::PAD_ZERO;
					extra_clr   = (fill_q == sha1_pkg::BLOCK_LAST);
				end else begin
					sc.byte_val = len_byte;
					final_set   = (fill_q == sha1_pkg::BLOCK_LAST);
				end
				if (fill_q == sha1_pkg::BLOCK_LAST) begin
					cc.load = 1'b1;
					state_d = sha1_pkg::ST_COMP;
				end
			end
			sha1_pkg::ST_COMP: begin
				sc.round_en = 1'b1;
				cc.round_en = 1'b1;
				if (rnd_q == sha1_pkg::ROUND_LAST) begin
					state_d = sha1_pkg::ST_ADD;
				end
			end
			sha1_pkg::ST_ADD: begin
				cc.add = 1'b1;
				if (final_q) begin
					state_d = sha1_pkg::ST_DONE;
				end else if (pad_q) begin
					state_d = sha1_pkg::ST_PAD;
				end else begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			sha1_pkg::ST_DONE: begin
				// hold until the previous digest has fully drained
				if (!out_valid_q) begin
					load_out  = 1'b1;
					cc.init   = 1'b1;
					clear_msg = 1'b1;
					state_d   = sha1_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			byte_cnt_q <= '0;
			rnd_q      <= '0;
			pad_q      <= 1'b0;
			mark_q     <= 1'b0;
			extra_q    <= 1'b0;
			final_q    <= 1'b0;
		end else begin
			if (fill_adv) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cnt_adv) begin
				byte_cnt_q <= byte_cnt_q + 61'd1;
			end
			if (state_q == sha1_pkg::ST_COMP) begin
				rnd_q <= (rnd_q == sha1_pkg::ROUND_LAST) ? 7'd0 : rnd_q + 7'd1;
			end
			if (pad_set) begin
				pad_q <= 1'b1;
			end
			if (mark_set) begin
				mark_q <= 1'b1;
			end
			if (extra_set) begin
				extra_q <= 1'b1;
			end else if (extra_clr) begin
				extra_q <= 1'b0;
			end
			if (final_set) begin
				final_q <= 1'b1;
			end
			if (clear_msg) begin
				fill_q     <= '0;
				byte_cnt_q <= '0;
				pad_q      <= 1'b0;
				mark_q     <= 1'b0;
				extra_q    <= 1'b0;
				final_q    <= 1'b0;
			end
		end
	end

	// Digest buffer: word 0 is always the one on offer; advance by shifting down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (out_fire) begin
			idx_q <= idx_q + 3'd1;
			if (idx_q == sha1_pkg::LAST_IDX) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			dig_q <= h;
		end else if (out_fire) begin
			for (int i = 0; i < sha1_pkg::NUM_H - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
	end

	assign out_valid            = out_valid_q;
	assign out_data.digest_word = dig_q[0];
	assign out_data.word_index  = idx_q;
	assign out_data.last_word   = (idx_q == sha1_pkg::LAST_IDX);

	sha1_sched u_sched (
		.clk  (clk),
		.ctrl (sc),
		.w_t  (w_t)
	);

	sha1_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cc),
		.w_t    (w_t),
		.h      (h)
	);

`ifndef ASSERT_OFF
	// a compression always starts on a freshly completed block
	a_comp_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1_pkg::ST_COMP) |-> (fill_q == 6'd0))
		else $error("compression running on a partial block");

	// round loop stays within 80 rounds and leaves through the chaining add
	a_round_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1_pkg::ST_COMP && rnd_q == sha1_pkg::ROUND_LAST)
		|=> (state_q == sha1_pkg::ST_ADD && rnd_q == 7'd0))
		else $error("round loop did not finish after 80 rounds");

	// the digest buffer is never reloaded while words are still on offer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q)
		else $error("digest loaded over undelivered words");

	// word index never runs past h4 while a beat is on offer
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (idx_q <= sha1_pkg::LAST_IDX))
		else $error("digest word index out of range");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for sha1_message_hasher, byte stream in and digest words out.
// Depends on sha1_pkg for the beat types and on the sha1_message_hasher RTL.
module tb;

	localparam int unsigned BLOCK_BYTES    = 64;
	localparam int unsigned LENGTH_OFFSET  = 56;
	localparam int unsigned DIGEST_WORDS   = 5;
	localparam int unsigned LAST_WORD_IDX  = 4;
	localparam logic [7:0]  PAD_MARKER     = 8'h80;
	localparam logic [7:0]  PAD_FILL       = 8'h00;
	localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hefcdab89, 32'h98badcfe,
		32'h10325476, 32'hc3d2e1f0};
	localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
	localparam logic [31:0] K_PARITY1  = 32'h6ED9EBA1;
	localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
	localparam logic [31:0] K_PARITY2  = 32'hCA62C1D6;

	localparam int unsigned BYTE_TARGET    = 370;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned HOLD_AFTER     = 10;
	localparam int unsigned DRAIN_CYCLES   = 200;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	// output-side ready pattern, picked anew for each stretch
	typedef enum logic [1:0] {
		RX_FREE,
		RX_SPARSE,
		RX_COIN,
		RX_PERIODIC
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sha1_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sha1_pkg::out_item_t out_data;

	// stimulus and scoreboard
	sha1_pkg::in_item_t pending[$];
	sha1_pkg::out_item_t digest_expect[$];
	int unsigned queued_items = 0;
	int unsigned mismatches = 0;
	int unsigned out_beats = 0;

	// predictor state: chaining words, block buffer, fill level, bit length
	logic [31:0] chain_h[DIGEST_WORDS];
	logic [7:0]  blk_bytes[BLOCK_BYTES];
	int unsigned fill_level;
	logic [63:0] msg_bits;

	// driver burst bookkeeping
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	// receiver pattern and long hold-off
	rx_mode_t rx_mode = RX_FREE;
	int unsigned rx_left = 0;
	int unsigned hold_left = 0;
	logic hold_done = 1'b0;
	logic [1:0] rx_phase = '0;

	int unsigned quiet_cycles = 0;

	sha1_message_hasher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Reload the chaining words and clear the length; the buffer needs no clearing
	// because every path writes each byte before it is read.
	task automatic restart_message();
		int unsigned i;
		for (i = 0; i < DIGEST_WORDS; i++)
			chain_h[i] = SHA1_IV[159 - 32 * i -: 32];
		fill_level = 0;
		msg_bits = '0;
	endtask

	// One 80-round compression of blk_bytes into chain_h, rolling 16-word schedule.
	task automatic fold_block();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, e, f, k, t;
		int unsigned r, s;
		for (r = 0; r < 16; r++)
			w[r] = {blk_bytes[4 * r], blk_bytes[4 * r + 1], blk_bytes[4 * r + 2],
				blk_bytes[4 * r + 3]};
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (r = 0; r < 80; r++) begin
			s = r & 15;
			if (r >= 16)
				w[s] = rotl(w[(s + 13) & 15] ^ w[(s + 8) & 15] ^ w[(s + 2) & 15] ^ w[s], 1);
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_CHOOSE;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_PARITY1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJORITY;
			end else begin
				f = b ^ c ^ d;
				k = K_PARITY2;
			end
			t = rotl(a, 5) + f + e + w[s] + k;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	// Advance the predictor by one accepted input beat; on end of message pad,
	// compress once or twice and queue the five digest words.
	task automatic absorb_beat(input sha1_pkg::in_item_t it);
		sha1_pkg::out_item_t word;
		int unsigned i;
		if (it.byte_present) begin
			blk_bytes[fill_level] = it.data_byte;
			fill_level++;
			msg_bits += 64'd8;
			if (fill_level == BLOCK_BYTES) begin
				fold_block();
				fill_level = 0;
			end
		end
		if (!it.end_of_message)
			return;
		blk_bytes[fill_level] = PAD_MARKER;
		fill_level++;
		// no room left for the length field: close this block first
		if (fill_level > LENGTH_OFFSET) begin
			for (i = fill_level; i < BLOCK_BYTES; i++)
				blk_bytes[i] = PAD_FILL;
			fold_block();
			fill_level = 0;
		end
		for (i = fill_level; i < LENGTH_OFFSET; i++)
			blk_bytes[i] = PAD_FILL;
		for (i = 0; i < 8; i++)
			blk_bytes[LENGTH_OFFSET + i] = msg_bits[63 - 8 * i -: 8];
		fold_block();
		for (i = 0; i < DIGEST_WORDS; i++) begin
			word.digest_word = chain_h[i];
			word.word_index = 3'(i);
			word.last_word = (i == LAST_WORD_IDX);
			digest_expect.push_back(word);
		end
		restart_message();
	endtask

	task automatic push_item(input logic [7:0] data, input logic present, input logic eom);
		sha1_pkg::in_item_t it;
		it.data_byte = data;
		it.byte_present = present;
		it.end_of_message = eom;
		pending.push_back(it);
		if (present || eom)
			queued_items++;
	endtask

	// Queue a message of len random bytes. The end mark rides on the last byte or
	// on a separate empty beat; idle beats are sprinkled in at noise_pct percent.
	task automatic queue_message(input int unsigned len, input bit tail_on_byte,
		input int unsigned noise_pct);
		int unsigned n;
		for (n = 0; n < len; n++) begin
			if ($urandom_range(0, 99) < noise_pct)
				push_item(8'($urandom), 1'b0, 1'b0);
			push_item(8'($urandom), 1'b1, tail_on_byte && (n == len - 1));
		end
		if (!tail_on_byte || len == 0)
			push_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Sender: bursts of random length separated by random gaps, some gaps zero so
	// that long back-to-back stretches occur. Hold valid and payload until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0 || pending.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0)
					gap_left <= gap_left - 1;
			end else begin
				in_valid <= 1'b1;
				in_data <= pending.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver: a ready pattern that changes after each stretch of random length, plus one long
	// hold-off once a couple of digests have left, so the output buffer backs up
	// and the block has to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode <= RX_FREE;
			rx_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
			rx_phase <= '0;
		end else begin
			rx_phase <= rx_phase + 2'd1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && out_beats >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode <= rx_mode_t'($urandom_range(0, 3));
					rx_left <= $urandom_range(8, 60);
				end else begin
					rx_left <= rx_left - 1;
				end
				case (rx_mode)
					RX_FREE:     out_ready <= 1'b1;
					RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
					RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: out_ready <= (rx_phase != 2'd0);
					default:     out_ready <= 1'b1;
				endcase
			end
		end
	end

	// Monitor: predict on every accepted input beat, then check every accepted
	// output beat against the oldest expected digest word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				absorb_beat(in_data);
			if (out_valid && out_ready) begin
				out_beats <= out_beats + 1;
				if (digest_expect.size() == 0) begin
					$display("%0t: unexpected digest beat %h/%0d/%0b", $time,
						out_data.digest_word, out_data.word_index, out_data.last_word);
					mismatches++;
				end else begin
					if (out_data.digest_word !== digest_expect[0].digest_word ||
						out_data.word_index !== digest_expect[0].word_index ||
						out_data.last_word !== digest_expect[0].last_word) begin
						$display("%0t: digest beat mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
							$time, digest_expect[0].digest_word, digest_expect[0].word_index,
							digest_expect[0].last_word, out_data.digest_word,
							out_data.word_index, out_data.last_word);
						mismatches++;
					end
					void'(digest_expect.pop_front());
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned len;
		restart_message();

		// Directed: empty message with junk on the data lines, an idle beat, one-byte
		// messages with the byte extremes, a three-byte message, a message closed by
		// an empty end beat, and two empty messages back to back.
		push_item(8'hFF, 1'b0, 1'b1);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'hFF, 1'b1, 1'b1);
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'h63, 1'b1, 1'b1);
		push_item(8'h5A, 1'b1, 1'b0);
		push_item(8'hA5, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'h3C, 1'b0, 1'b1);
		push_item(8'h00, 1'b0, 1'b1);
		push_item(8'hC3, 1'b0, 1'b1);

		// Random messages: mostly short, many around the padding boundaries
		// (length field fits, just misses, full block), a few longer than one block.
		while (queued_items < BYTE_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: len = $urandom_range(0, 12);
				5, 6, 7: len = $urandom_range(0, 1) ? 54 + $urandom_range(0, 3)
					: 62 + $urandom_range(0, 3);
				8: len = $urandom_range(100, 130);
				default: len = $urandom_range(0, 3);
			endcase
			queue_message(len, 1'($urandom_range(0, 1)),
				($urandom_range(0, 2) == 0) ? 0 : 8);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// drain: input queue, then outstanding digests, then a quiet tail
		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (digest_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sha1_message_hasher.f
src/sha1_pkg.sv
src/sha1_sched.sv
src/sha1_core.sv
src/sha1_message_hasher.sv
bench/tb.sv
